FILE: rtl/gcsp_pkg.sv
// Shared types and constants for the generation-checked slot pool.
`default_nettype none
package gcsp_pkg;

  localparam int unsigned SLOTS    = 256;
  localparam int unsigned GEN_BITS = 32;
  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam int unsigned LINK_W   = SLOT_W + 1;
  localparam int unsigned CNT_W    = SLOT_W + 1;

  localparam logic [LINK_W-1:0]   LINK_NIL = {LINK_W{1'b1}};
  localparam logic [GEN_BITS-1:0] GEN_MAX  = {GEN_BITS{1'b1}};
  localparam logic [GEN_BITS-1:0] GEN_INIT = GEN_BITS'(1);

  typedef enum logic [1:0] {
    MODE_FREE     = 2'd0,
    MODE_WRITABLE = 2'd1,
    MODE_SEALED   = 2'd2,
    MODE_RETIRED  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OP_ACQUIRE    = 3'd0,
    OP_WRITABLE   = 3'd1,
    OP_SEAL       = 3'd2,
    OP_READ_PAY   = 3'd3,
    OP_READ_META  = 3'd4,
    OP_REL_WRITE  = 3'd5,
    OP_REL_SEALED = 3'd6,
    OP_CLOSE      = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_FAILED        = 4'd1,
    ST_NOT_ACCEPTING = 4'd2,
    ST_EXHAUSTED     = 4'd3,
    ST_NO_FREE       = 4'd4,
    ST_FOREIGN       = 4'd5,
    ST_STALE         = 4'd6,
    ST_TYPE          = 4'd7,
    ST_PAYLOAD_LONG  = 4'd8,
    ST_META_LONG     = 4'd9,
    ST_INTERNAL      = 4'd10
  } status_e;

  typedef enum logic [1:0] {
    CFG_IDENTITY = 2'd0,
    CFG_COUNT    = 2'd1,
    CFG_PAY_CAP  = 2'd2,
    CFG_META_CAP = 2'd3
  } cfg_e;

  typedef struct packed {
    mode_e               mode;
    logic [GEN_BITS-1:0] gen;
    logic [LINK_W-1:0]   link;
    logic [15:0]         plen;
    logic [11:0]         mlen;
  } slot_rec_t;

  localparam int unsigned REC_W = $bits(slot_rec_t);

endpackage
`default_nettype wire

FILE: rtl/gcsp_ram.sv
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module gcsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/generation_checked_slot_pool_core.sv
// Top level of the generation-checked slot pool: request sequencer around the slot RAM.
//
//  channel  | signals                          | direction
//  request  | s_axis_tvalid/tready/tdata/tuser | in
//  result   | m_axis_tvalid/tready/tdata/tuser | out
//  config   | cfg_we_i/cfg_idx_i/cfg_data_i    | in
//
// For each request the slot record is read from the RAM in the accept cycle and
// modified and written back in the S_EXEC state, as the RAM has a single port.
// Untouched slots read as their rebuilt value through per-slot valid bits, so reset
// and a pool-size write take effect at once with no clearing pass.
// A result waiting on m_axis_tready holds the write-back cycle; nothing is dropped.
`default_nettype none
module generation_checked_slot_pool_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] handle_pool, [39:32] handle_slot, [71:40] handle_generation,
  // [72] type_matches, [88:73] payload_length, [104:89] metadata_length
  input  wire logic [111:0] s_axis_tdata,
  // [2:0] op
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [7:0] slot number, [39:8] slot_generation, [63:40] byte_offset,
  // [79:64] byte_length, [88:80] free_count, [97:89] writable_count,
  // [106:98] sealed_count, [115:107] retired_count, [116] is_accepting,
  // [117] is_failed, [118] is_exhausted
  output logic      [119:0] m_axis_tdata,
  // [3:0] status
  output logic      [3:0]   m_axis_tuser,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i
);
  localparam int unsigned SW = gcsp_pkg::SLOT_W;
  localparam int unsigned LW = gcsp_pkg::LINK_W;
  localparam int unsigned CW = gcsp_pkg::CNT_W;
  localparam int unsigned GW = gcsp_pkg::GEN_BITS;

  typedef enum logic {S_IDLE, S_EXEC} state_e;

  state_e state_q;
  logic [31:0] ident_q;
  logic [CW-1:0] count_q;
  logic [15:0] pcap_q;
  logic [11:0] mcap_q;
  logic [gcsp_pkg::SLOTS-1:0] valid_q;
  logic [LW-1:0] head_q, head_d;
  logic [CW-1:0] cf_q, cf_d, cw_q, cw_d, cs_q, cs_d, cr_q, cr_d;
  logic acc_q, acc_d, fail_q, fail_d, exh_q, exh_d;
  logic [3:0] err_q, err_d;

  gcsp_pkg::op_e op_q;
  logic [31:0] hp_q;
  logic [SW-1:0] hs_q;
  logic [31:0] hg_q;
  logic tm_q;
  logic [15:0] plen_q, mlen_q;
  logic [SW-1:0] addr_q;

  logic out_valid_q;
  logic [3:0] st_q;
  logic [7:0] idx_q;
  logic [31:0] gen_q;
  logic [23:0] off_q;
  logic [15:0] len_q;

  logic accept, exec_go;
  logic [SW-1:0] ram_addr;
  logic [gcsp_pkg::REC_W-1:0] ram_rdata;
  gcsp_pkg::slot_rec_t rec, wrec, dflt;
  logic ram_we;

  gcsp_pkg::status_e st;
  logic [7:0] idx;
  logic [31:0] gen_o;
  logic [23:0] off;
  logic [15:0] len;
  logic [CW-1:0] hs_ext, addr_ext, rcnt;
  logic [CW:0] next_ext;
  logic [15:0] cap;
  logic [15:0] slen;
  logic foreign, stale;
  gcsp_pkg::mode_e want;
  logic [8:0] ncount;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign exec_go  = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);
  assign ram_addr = accept ? ((s_axis_tuser == gcsp_pkg::OP_ACQUIRE) ? head_q[SW-1:0]
                                                                     : s_axis_tdata[39:32])
                           : addr_q;

  gcsp_ram #(.WIDTH(gcsp_pkg::REC_W), .DEPTH(gcsp_pkg::SLOTS)) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(wrec),
    .rdata_o(ram_rdata)
  );

  // Slot record as rebuilt, for entries not written since the last rebuild.
  always_comb begin
    addr_ext  = CW'(addr_q);
    next_ext  = (CW+1)'(addr_q) + (CW+1)'(1);
    dflt.mode = (addr_ext < count_q) ? gcsp_pkg::MODE_FREE : gcsp_pkg::MODE_RETIRED;
    dflt.gen  = gcsp_pkg::GEN_INIT;
    dflt.link = (next_ext < (CW+1)'(count_q)) ? LW'(next_ext) : gcsp_pkg::LINK_NIL;
    dflt.plen = '0;
    dflt.mlen = '0;
    rec = valid_q[addr_q] ? gcsp_pkg::slot_rec_t'(ram_rdata) : dflt;
  end

  always_comb begin
    hs_ext = CW'(hs_q);
    want = (op_q == gcsp_pkg::OP_READ_PAY || op_q == gcsp_pkg::OP_READ_META ||
            op_q == gcsp_pkg::OP_REL_SEALED) ? gcsp_pkg::MODE_SEALED
                                             : gcsp_pkg::MODE_WRITABLE;
    foreign = (hp_q == '0) || (hp_q != ident_q) || (hg_q == '0) || (hs_ext >= count_q);
    stale   = (rec.mode != want) || (rec.gen != GW'(hg_q));
    cap  = (op_q == gcsp_pkg::OP_READ_META) ? 16'(mcap_q) : pcap_q;
    slen = (op_q == gcsp_pkg::OP_READ_META) ? 16'(rec.mlen) : rec.plen;
    rcnt = (op_q == gcsp_pkg::OP_REL_WRITE) ? cw_q : cs_q;

    st    = gcsp_pkg::ST_OK;
    idx   = (op_q == gcsp_pkg::OP_ACQUIRE || op_q == gcsp_pkg::OP_CLOSE) ? 8'd0 : 8'(hs_q);
    gen_o = '0;
    off   = '0;
    len   = '0;
    wrec  = rec;
    ram_we = 1'b0;
    head_d = head_q;
    cf_d = cf_q; cw_d = cw_q; cs_d = cs_q; cr_d = cr_q;
    acc_d = acc_q; fail_d = fail_q; exh_d = exh_q; err_d = err_q;

    if (op_q <= gcsp_pkg::OP_READ_META && fail_q) begin
      st = (err_q != 4'd0) ? gcsp_pkg::status_e'(err_q) : gcsp_pkg::ST_FAILED;
    end else begin
      unique case (op_q)
        gcsp_pkg::OP_ACQUIRE: begin
          if (!acc_q) begin
            st = exh_q ? gcsp_pkg::ST_EXHAUSTED : gcsp_pkg::ST_NOT_ACCEPTING;
          end else if (cf_q == '0 || head_q == gcsp_pkg::LINK_NIL) begin
            if (cf_q != '0 || head_q != gcsp_pkg::LINK_NIL) begin
              st = gcsp_pkg::ST_INTERNAL;
            end else begin
              st = gcsp_pkg::ST_NO_FREE;
            end
          end else if (CW'(head_q) >= count_q) begin
            st = gcsp_pkg::ST_INTERNAL;
          end else if (rec.mode != gcsp_pkg::MODE_FREE || rec.gen == '0 ||
                       (rec.link != gcsp_pkg::LINK_NIL && CW'(rec.link) >= count_q)) begin
            st = gcsp_pkg::ST_INTERNAL;
          end else begin
            head_d = rec.link;
            wrec.mode = gcsp_pkg::MODE_WRITABLE;
            wrec.plen = '0;
            wrec.mlen = '0;
            wrec.link = gcsp_pkg::LINK_NIL;
            ram_we = 1'b1;
            cf_d = cf_q - CW'(1);
            cw_d = cw_q + CW'(1);
            idx = 8'(addr_q);
            gen_o = 32'(rec.gen);
          end
        end
        gcsp_pkg::OP_WRITABLE, gcsp_pkg::OP_READ_PAY, gcsp_pkg::OP_READ_META: begin
          if (foreign) begin
            st = gcsp_pkg::ST_FOREIGN;
          end else if (stale) begin
            st = gcsp_pkg::ST_STALE;
          end else if (op_q == gcsp_pkg::OP_WRITABLE) begin
            off = 24'(hs_q) * 24'(pcap_q);
            len = pcap_q;
          end else if (slen > cap) begin
            st = gcsp_pkg::ST_INTERNAL;
          end else begin
            off = 24'(hs_q) * 24'(cap);
            len = slen;
          end
        end
        gcsp_pkg::OP_SEAL: begin
          if (foreign) begin
            st = gcsp_pkg::ST_FOREIGN;
          end else if (stale) begin
            st = gcsp_pkg::ST_STALE;
          end else if (!tm_q) begin
            st = gcsp_pkg::ST_TYPE;
          end else if (plen_q > pcap_q) begin
            st = gcsp_pkg::ST_PAYLOAD_LONG;
          end else if (mlen_q > 16'(mcap_q)) begin
            st = gcsp_pkg::ST_META_LONG;
          end else if (cw_q == '0) begin
            st = gcsp_pkg::ST_INTERNAL;
          end else begin
            wrec.plen = plen_q;
            wrec.mlen = mlen_q[11:0];
            wrec.mode = gcsp_pkg::MODE_SEALED;
            ram_we = 1'b1;
            cw_d = cw_q - CW'(1);
            cs_d = cs_q + CW'(1);
            gen_o = 32'(rec.gen);
            len = plen_q;
          end
        end
        gcsp_pkg::OP_REL_WRITE, gcsp_pkg::OP_REL_SEALED: begin
          if (foreign || stale || rcnt == '0) begin
            st = gcsp_pkg::ST_FAILED;
            fail_d = 1'b1;
            acc_d = 1'b0;
          end else begin
            if (op_q == gcsp_pkg::OP_REL_WRITE) begin
              cw_d = cw_q - CW'(1);
            end else begin
              cs_d = cs_q - CW'(1);
            end
            wrec.plen = '0;
            wrec.mlen = '0;
            ram_we = 1'b1;
            if (rec.gen == gcsp_pkg::GEN_MAX) begin
              wrec.mode = gcsp_pkg::MODE_RETIRED;
              wrec.link = gcsp_pkg::LINK_NIL;
              cr_d = cr_q + CW'(1);
              acc_d = 1'b0;
              exh_d = 1'b1;
            end else if (head_q != gcsp_pkg::LINK_NIL && CW'(head_q) >= count_q) begin
              // corrupt free list: retire the slot and fail closed
              wrec.mode = gcsp_pkg::MODE_RETIRED;
              wrec.link = gcsp_pkg::LINK_NIL;
              cr_d = cr_q + CW'(1);
              fail_d = 1'b1;
              acc_d = 1'b0;
              st = gcsp_pkg::ST_FAILED;
            end else begin
              wrec.gen = rec.gen + GW'(1);
              wrec.mode = gcsp_pkg::MODE_FREE;
              wrec.link = head_q;
              head_d = LW'(hs_q);
              cf_d = cf_q + CW'(1);
            end
          end
        end
        default: begin
          acc_d = 1'b0;
        end
      endcase
      if (st == gcsp_pkg::ST_INTERNAL) begin
        fail_d = 1'b1;
        acc_d = 1'b0;
        err_d = gcsp_pkg::ST_INTERNAL;
      end
    end
    if (!exec_go) begin
      ram_we = 1'b0;
    end
  end

  always_comb begin
    ncount = cfg_data_i[8:0];
    if (ncount == 9'd0) begin
      ncount = 9'd1;
    end else if (32'(ncount) > gcsp_pkg::SLOTS) begin
      ncount = 9'(gcsp_pkg::SLOTS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ident_q <= 32'd1;
      count_q <= CW'(gcsp_pkg::SLOTS);
      pcap_q <= 16'd4096;
      mcap_q <= 12'd64;
      valid_q <= '0;
      head_q <= '0;
      cf_q <= CW'(gcsp_pkg::SLOTS);
      cw_q <= '0;
      cs_q <= '0;
      cr_q <= '0;
      acc_q <= 1'b1;
      fail_q <= 1'b0;
      exh_q <= 1'b0;
      err_q <= '0;
      out_valid_q <= 1'b0;
      st_q <= '0;
      idx_q <= '0;
      gen_q <= '0;
      off_q <= '0;
      len_q <= '0;
    end else begin
      // load a new word, or drop the one the receiver took
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (gcsp_pkg::cfg_e'(cfg_idx_i))
          gcsp_pkg::CFG_IDENTITY: ident_q <= cfg_data_i;
          gcsp_pkg::CFG_COUNT: begin
            // rebuild the pool
            count_q <= CW'(ncount);
            valid_q <= '0;
            head_q <= '0;
            cf_q <= CW'(ncount);
            cw_q <= '0;
            cs_q <= '0;
            cr_q <= '0;
            acc_q <= 1'b1;
            fail_q <= 1'b0;
            exh_q <= 1'b0;
            err_q <= '0;
          end
          gcsp_pkg::CFG_PAY_CAP:  pcap_q <= cfg_data_i[15:0];
          gcsp_pkg::CFG_META_CAP: mcap_q <= cfg_data_i[11:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            state_q <= S_IDLE;
            if (ram_we) begin
              valid_q[addr_q] <= 1'b1;
            end
            head_q <= head_d;
            cf_q <= cf_d;
            cw_q <= cw_d;
            cs_q <= cs_d;
            cr_q <= cr_d;
            acc_q <= acc_d;
            fail_q <= fail_d;
            exh_q <= exh_d;
            err_q <= err_d;
            st_q  <= st;
            idx_q <= idx;
            gen_q <= gen_o;
            off_q <= off;
            len_q <= len;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= gcsp_pkg::op_e'(s_axis_tuser);
      hp_q   <= s_axis_tdata[31:0];
      hs_q   <= s_axis_tdata[39:32];
      hg_q   <= s_axis_tdata[71:40];
      tm_q   <= s_axis_tdata[72];
      plen_q <= s_axis_tdata[88:73];
      mlen_q <= s_axis_tdata[104:89];
      addr_q <= ram_addr;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = st_q;
  assign m_axis_tdata  = {1'b0, exh_q, fail_q, acc_q, cr_q, cs_q, cw_q, cf_q,
                          len_q, off_q, gen_q, idx_q};

  // every slot in use is counted in exactly one mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (12'(cf_q) + 12'(cw_q) + 12'(cs_q) + 12'(cr_q)) == 12'(count_q))
    else $error("slot counters do not add up to the pool size");

  assert property (@(posedge clk_i) disable iff (!rst_ni) fail_q |-> !acc_q)
    else $error("failed pool still accepting");

  assert property (@(posedge clk_i) disable iff (!rst_ni) exh_q |-> !acc_q)
    else $error("exhausted pool still accepting");

  assert property (@(posedge clk_i) disable iff (!rst_ni) ram_we |-> state_q == S_EXEC)
    else $error("slot RAM written outside the write-back cycle");

endmodule
`default_nettype wire

FILE: tb/tb_generation_checked_slot_pool_core.sv
// Self-checking testbench for the generation-checked slot pool core.
`default_nettype none
module tb_generation_checked_slot_pool_core;
  import gcsp_pkg::*;

  typedef struct {
    op_e         op;
    logic [31:0] hpool;
    logic [7:0]  hslot;
    logic [31:0] hgen;
    logic        tmatch;
    logic [15:0] plen;
    logic [15:0] mlen;
  } req_t;

  typedef struct {
    status_e     st;
    logic [7:0]  idx;
    logic [31:0] gen;
    logic [23:0] off;
    logic [15:0] len;
    logic [8:0]  nfree, nwrit, nseal, nret;
    logic        acc, fld, exh;
  } pool_result_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [111:0] s_axis_tdata;
  logic [2:0] s_axis_tuser;
  logic [119:0] m_axis_tdata;
  logic [3:0] m_axis_tuser;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [31:0] cfg_data_i;

  generation_checked_slot_pool_core dut (.*);

  // predicted pool state
  logic [31:0] p_ident;
  int unsigned p_count, p_paycap, p_metacap;
  mode_e       p_mode [SLOTS];
  logic [31:0] p_gen [SLOTS];
  logic [8:0]  p_link [SLOTS];
  logic [15:0] p_plen [SLOTS];
  logic [11:0] p_mlen [SLOTS];
  logic [8:0]  p_head;
  int unsigned p_nfree, p_nwrit, p_nseal, p_nret;
  logic        p_acc, p_fld, p_exh;
  status_e     p_err;
  logic        p_has_err;

  pool_result_t pending_results[$];
  int errors = 0, items_sent = 0, results_seen = 0, cycles = 0;
  int send_idle_pct = 0, stall_pct = 0, hold_cycles = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic rebuild_pool();
    for (int i = 0; i < SLOTS; i++) begin
      p_mode[i] = (i < p_count) ? MODE_FREE : MODE_RETIRED;
      p_gen[i]  = 32'd1;
      p_link[i] = (i + 1 < p_count) ? 9'(i + 1) : LINK_NIL;
      p_plen[i] = '0;
      p_mlen[i] = '0;
    end
    p_head = '0;
    p_nfree = p_count;
    p_nwrit = 0; p_nseal = 0; p_nret = 0;
    p_acc = 1; p_fld = 0; p_exh = 0; p_has_err = 0;
  endtask

  function automatic status_e fail_internal();
    p_fld = 1; p_acc = 0; p_has_err = 1; p_err = ST_INTERNAL;
    return ST_INTERNAL;
  endfunction

  function automatic status_e check_handle(req_t r, mode_e m);
    if (r.hpool == 0 || r.hpool != p_ident || r.hgen == 0 || r.hslot >= p_count)
      return ST_FOREIGN;
    if (p_mode[r.hslot] != m || p_gen[r.hslot] != r.hgen) return ST_STALE;
    return ST_OK;
  endfunction

  function automatic status_e recycle_slot(int s, mode_e m);
    if (p_mode[s] != m) begin
      p_fld = 1; p_acc = 0;
      return ST_FAILED;
    end
    if (m == MODE_WRITABLE) p_nwrit--; else p_nseal--;
    p_plen[s] = '0; p_mlen[s] = '0;
    if (p_gen[s] == GEN_MAX) begin
      p_mode[s] = MODE_RETIRED; p_link[s] = LINK_NIL; p_nret++;
      p_acc = 0; p_exh = 1;
      return ST_OK;
    end
    if (p_head != LINK_NIL && p_head >= p_count) begin
      p_mode[s] = MODE_RETIRED; p_link[s] = LINK_NIL; p_nret++;
      p_fld = 1; p_acc = 0;
      return ST_FAILED;
    end
    p_gen[s]++;
    p_mode[s] = MODE_FREE;
    p_link[s] = p_head;
    p_head = 9'(s);
    p_nfree++;
    return ST_OK;
  endfunction

  // Apply one accepted request to the predicted pool and queue its result.
  function automatic void predict_pool_op(req_t r);
    pool_result_t e;
    int unsigned cap, l;
    int s;
    e.st = ST_OK; e.idx = r.hslot; e.gen = '0; e.off = '0; e.len = '0;
    if (r.op == OP_ACQUIRE || r.op == OP_CLOSE) e.idx = '0;
    if (r.op <= OP_READ_META && p_fld) begin
      e.st = p_has_err ? p_err : ST_FAILED;
    end else begin
      case (r.op)
        OP_ACQUIRE: begin
          if (!p_acc) e.st = p_exh ? ST_EXHAUSTED : ST_NOT_ACCEPTING;
          else if (p_nfree == 0 || p_head == LINK_NIL)
            e.st = (p_nfree != 0 || p_head != LINK_NIL) ? fail_internal() : ST_NO_FREE;
          else if (p_head >= p_count) e.st = fail_internal();
          else begin
            s = p_head;
            if (p_mode[s] != MODE_FREE || p_gen[s] == 0 ||
                (p_link[s] != LINK_NIL && p_link[s] >= p_count)) begin
              e.st = fail_internal();
            end else begin
              p_head = p_link[s];
              p_mode[s] = MODE_WRITABLE;
              p_plen[s] = '0; p_mlen[s] = '0;
              p_link[s] = LINK_NIL;
              p_nfree--; p_nwrit++;
              e.idx = 8'(s);
              e.gen = p_gen[s];
            end
          end
        end
        OP_WRITABLE: begin
          e.st = check_handle(r, MODE_WRITABLE);
          if (e.st == ST_OK) begin
            e.off = 24'(r.hslot) * 24'(p_paycap);
            e.len = 16'(p_paycap);
          end
        end
        OP_SEAL: begin
          e.st = check_handle(r, MODE_WRITABLE);
          if (e.st == ST_OK) begin
            if (!r.tmatch) e.st = ST_TYPE;
            else if (r.plen > p_paycap) e.st = ST_PAYLOAD_LONG;
            else if (r.mlen > p_metacap) e.st = ST_META_LONG;
            else if (p_nwrit == 0) e.st = fail_internal();
            else begin
              p_plen[r.hslot] = r.plen;
              p_mlen[r.hslot] = 12'(r.mlen);
              p_mode[r.hslot] = MODE_SEALED;
              p_nwrit--; p_nseal++;
              e.gen = p_gen[r.hslot];
              e.len = r.plen;
            end
          end
        end
        OP_READ_PAY, OP_READ_META: begin
          e.st = check_handle(r, MODE_SEALED);
          if (e.st == ST_OK) begin
            cap = (r.op == OP_READ_PAY) ? p_paycap : p_metacap;
            l = (r.op == OP_READ_PAY) ? p_plen[r.hslot] : p_mlen[r.hslot];
            if (l > cap) e.st = fail_internal();
            else begin
              e.off = 24'(r.hslot) * 24'(cap);
              e.len = 16'(l);
            end
          end
        end
        OP_REL_WRITE, OP_REL_SEALED: begin
          if (check_handle(r, (r.op == OP_REL_WRITE) ? MODE_WRITABLE : MODE_SEALED) != ST_OK
              || ((r.op == OP_REL_WRITE) ? p_nwrit : p_nseal) == 0) begin
            p_fld = 1; p_acc = 0;
            e.st = ST_FAILED;
          end else begin
            e.st = recycle_slot(r.hslot, (r.op == OP_REL_WRITE) ? MODE_WRITABLE : MODE_SEALED);
          end
        end
        default: p_acc = 0;
      endcase
    end
    e.nfree = 9'(p_nfree); e.nwrit = 9'(p_nwrit);
    e.nseal = 9'(p_nseal); e.nret = 9'(p_nret);
    e.acc = p_acc; e.fld = p_fld; e.exh = p_exh;
    pending_results.push_back(e);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("[%0d] result %0d: %s got 0x%0h want 0x%0h", cycles, results_seen, what, got,
             want);
  endtask

  // result checker
  always @(posedge clk_i) begin
    pool_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, tdata", m_axis_tdata[63:0], 0);
      end else begin
        e = pending_results.pop_front();
        if (m_axis_tuser != e.st) report_mismatch("status", m_axis_tuser, e.st);
        if (m_axis_tdata[7:0] != e.idx) report_mismatch("slot number", m_axis_tdata[7:0], e.idx);
        if (m_axis_tdata[39:8] != e.gen) report_mismatch("generation", m_axis_tdata[39:8], e.gen);
        if (m_axis_tdata[63:40] != e.off) report_mismatch("offset", m_axis_tdata[63:40], e.off);
        if (m_axis_tdata[79:64] != e.len) report_mismatch("length", m_axis_tdata[79:64], e.len);
        if (m_axis_tdata[88:80] != e.nfree)
          report_mismatch("free_count", m_axis_tdata[88:80], e.nfree);
        if (m_axis_tdata[97:89] != e.nwrit)
          report_mismatch("writable_count", m_axis_tdata[97:89], e.nwrit);
        if (m_axis_tdata[106:98] != e.nseal)
          report_mismatch("sealed_count", m_axis_tdata[106:98], e.nseal);
        if (m_axis_tdata[115:107] != e.nret)
          report_mismatch("retired_count", m_axis_tdata[115:107], e.nret);
        if (m_axis_tdata[116] != e.acc) report_mismatch("accepting", m_axis_tdata[116], e.acc);
        if (m_axis_tdata[117] != e.fld) report_mismatch("failed", m_axis_tdata[117], e.fld);
        if (m_axis_tdata[118] != e.exh) report_mismatch("exhausted", m_axis_tdata[118], e.exh);
      end
    end
  end

  // result-side ready: random stalls, or a counted hold-off
  initial begin
    m_axis_tready = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_request(req_t r);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {7'd0, r.mlen, r.plen, r.tmatch, r.hgen, r.hslot, r.hpool};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_pool_op(r);
    items_sent++;
  endtask

  task automatic drain();
    @(posedge clk_i);
    s_axis_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Drain, then write one register and track it.
  task automatic write_reg(cfg_e idx, logic [31:0] val);
    int unsigned n;
    drain();
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    case (idx)
      CFG_IDENTITY: p_ident = val;
      CFG_COUNT: begin
        n = val[8:0];
        if (n == 0) n = 1;
        if (n > SLOTS) n = SLOTS;
        p_count = n;
        rebuild_pool();
      end
      CFG_PAY_CAP: p_paycap = val[15:0];
      default: p_metacap = val[11:0];
    endcase
  endtask

  function automatic req_t mk(op_e op, logic [7:0] s, logic [31:0] g,
                              logic tm = 1, logic [15:0] pl = 0, logic [15:0] ml = 0);
    req_t r;
    r.op = op; r.hpool = p_ident; r.hslot = s; r.hgen = g;
    r.tmatch = tm; r.plen = pl; r.mlen = ml;
    return r;
  endfunction

  task automatic test_lifecycle();
    req_t r;
    send_request(mk(OP_ACQUIRE, 0, 0));
    send_request(mk(OP_WRITABLE, 0, 1));
    send_request(mk(OP_SEAL, 0, 1, 0, 10, 10));
    send_request(mk(OP_SEAL, 0, 1, 1, 4097, 0));
    send_request(mk(OP_SEAL, 0, 1, 1, 0, 65));
    send_request(mk(OP_SEAL, 0, 1, 1, 4096, 64));
    send_request(mk(OP_READ_PAY, 0, 1));
    send_request(mk(OP_READ_META, 0, 1));
    send_request(mk(OP_WRITABLE, 0, 1));
    r = mk(OP_READ_PAY, 0, 1); r.hpool = 32'hFFFF_FFFF;
    send_request(r);
    send_request(mk(OP_READ_PAY, 0, 0));
    send_request(mk(OP_READ_META, 255, 1));
    send_request(mk(OP_REL_SEALED, 0, 1));
    send_request(mk(OP_ACQUIRE, 0, 0));
    send_request(mk(OP_CLOSE, 0, 0));
    send_request(mk(OP_ACQUIRE, 0, 0));
    send_request(mk(OP_REL_WRITE, 0, 2));
  endtask

  task automatic test_fail_closed();
    // shrunk capacity: stored length above the new capacity
    write_reg(CFG_COUNT, 2);
    send_request(mk(OP_ACQUIRE, 0, 0));
    send_request(mk(OP_SEAL, 0, 1, 1, 100, 3));
    write_reg(CFG_PAY_CAP, 50);
    send_request(mk(OP_READ_PAY, 0, 1));
    send_request(mk(OP_ACQUIRE, 0, 0));
    send_request(mk(OP_REL_SEALED, 0, 1));
    // bad release fails quietly
    write_reg(CFG_COUNT, 0);
    send_request(mk(OP_ACQUIRE, 0, 0));
    send_request(mk(OP_ACQUIRE, 0, 0));
    send_request(mk(OP_REL_SEALED, 0, 1));
    send_request(mk(OP_WRITABLE, 0, 1));
    write_reg(CFG_COUNT, 9'h1FF);
    write_reg(CFG_IDENTITY, 0);
    send_request(mk(OP_ACQUIRE, 0, 0));
    send_request(mk(OP_WRITABLE, 0, 1));
    write_reg(CFG_IDENTITY, 32'hFFFF_FFFF);
    write_reg(CFG_META_CAP, 0);
    write_reg(CFG_PAY_CAP, 65535);
    send_request(mk(OP_WRITABLE, 0, 1));
  endtask

  // Pick a request that mostly follows a live handle's lifecycle.
  function automatic req_t pick_request();
    req_t r;
    int s, k;
    k = $urandom_range(99);
    s = $urandom_range(p_count - 1);
    r = mk(OP_ACQUIRE, 8'(s), p_gen[s], 1, 16'($urandom_range(p_paycap)),
           16'($urandom_range(p_metacap)));
    if (k < 2) begin
      r.op = op_e'($urandom_range(7));
      r.hpool = $urandom; r.hslot = 8'($urandom); r.hgen = $urandom;
      r.tmatch = 1'($urandom); r.plen = 16'($urandom); r.mlen = 16'($urandom);
      if (r.op >= OP_REL_WRITE && $urandom_range(3) != 0) r.op = OP_READ_PAY;
    end else if (k < 6) begin
      r.op = op_e'($urandom_range(1, 4));
      case ($urandom_range(2))
        0: r.hpool = $urandom;
        1: r.hgen = (k & 1) ? 32'd0 : $urandom;
        default: r.hslot = 8'($urandom_range(255));
      endcase
    end else if (k == 6) begin
      r.op = OP_CLOSE;
    end else if (k < 35 || p_mode[s] == MODE_FREE || p_mode[s] == MODE_RETIRED) begin
      if (p_mode[s] == MODE_FREE && $urandom_range(4) == 0) r.op = OP_WRITABLE;
    end else if (p_mode[s] == MODE_WRITABLE) begin
      case ($urandom_range(5))
        0: r.op = OP_WRITABLE;
        1: r.op = OP_REL_WRITE;
        2: begin
          r.op = OP_SEAL; r.tmatch = 1'($urandom);
          r.plen = 16'($urandom); r.mlen = 16'($urandom);
        end
        default: r.op = OP_SEAL;
      endcase
    end else begin
      case ($urandom_range(2))
        0: r.op = OP_READ_PAY;
        1: r.op = OP_READ_META;
        default: r.op = OP_REL_SEALED;
      endcase
    end
    return r;
  endfunction

  task automatic test_random(int n_items);
    int chunk = 0;
    while (n_items > 0) begin
      case (chunk % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      if (p_fld || !p_acc || chunk % 5 == 0) begin
        if ($urandom_range(3) == 0) write_reg(CFG_IDENTITY, $urandom);
        if ($urandom_range(2) == 0)
          write_reg(CFG_PAY_CAP, $urandom_range(1) ? $urandom_range(1, 65535)
                                                   : $urandom_range(1, 200));
        if ($urandom_range(2) == 0) write_reg(CFG_META_CAP, $urandom_range(4095));
        write_reg(CFG_COUNT, ($urandom_range(9) == 0) ? 256 : $urandom_range(1, 12));
      end
      for (int i = 0; i < 60 && n_items > 0; i++) begin
        send_request(pick_request());
        n_items--;
      end
      chunk++;
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0; stall_pct = 0;
    write_reg(CFG_COUNT, 40);
    hold_cycles = 300;
    for (int i = 0; i < 30; i++) send_request(mk(OP_ACQUIRE, 0, 0));
  endtask

  initial begin
    rst_ni = 0;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
    cfg_we_i = 0; cfg_idx_i = CFG_IDENTITY; cfg_data_i = '0;
    p_ident = 32'd1; p_count = 256; p_paycap = 4096; p_metacap = 64;
    rebuild_pool();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    test_lifecycle();
    test_fail_closed();
    test_backpressure();
    test_random(1700);
    drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d requests and %0d results: lifecycle, fail-closed paths,",
             items_sent, results_seen);
    $display("register rebuilds, output hold-off and random idle/stall mixes");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, pending_results.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
